// ===== src/pse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg: shared constants, types and microcode for the postfix evaluator
// Holds stack sizing, character codes, status codes, control word layout
// and the sequencer program.
// ----------------------------------------------------------------------------
package pse_pkg;

    // stack sizing
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // divider: one quotient bit per step
    localparam int DIV_STEPS = 8;
    localparam int DIVCNT_W  = $clog2(DIV_STEPS);

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // result status
    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_UNDER   = 2'd1;
    localparam t_status ST_DIVZERO = 2'd2;
    localparam t_status ST_OVER    = 2'd3;

    // datapath actions
    typedef logic [2:0] t_act;
    localparam t_act ACT_NONE  = 3'd0;
    localparam t_act ACT_PUSH  = 3'd1;
    localparam t_act ACT_OPCHK = 3'd2;
    localparam t_act ACT_LOAD  = 3'd3;
    localparam t_act ACT_DIV   = 3'd4;
    localparam t_act ACT_WB    = 3'd5;
    localparam t_act ACT_EMIT  = 3'd6;

    // jump conditions
    typedef logic [3:0] t_jmp;
    localparam t_jmp J_NEXT       = 4'd0;
    localparam t_jmp J_GOTO       = 4'd1;
    localparam t_jmp J_WAIT_IN    = 4'd2;
    localparam t_jmp J_IF_OP      = 4'd3;
    localparam t_jmp J_IF_UNDER   = 4'd4;
    localparam t_jmp J_IF_NOTDIV  = 4'd5;
    localparam t_jmp J_DIV_LOOP   = 4'd6;
    localparam t_jmp J_IF_NOTLAST = 4'd7;
    localparam t_jmp J_OUT_WAIT   = 4'd8;

    // program steps
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step S_FETCH  = 4'd0;
    localparam t_step S_DECODE = 4'd1;
    localparam t_step S_PUSH   = 4'd2;
    localparam t_step S_OPCHK  = 4'd3;
    localparam t_step S_LOAD   = 4'd4;
    localparam t_step S_DIV    = 4'd5;
    localparam t_step S_WB     = 4'd6;
    localparam t_step S_END    = 4'd7;
    localparam t_step S_EMIT   = 4'd8;

    typedef struct packed {
        logic  in_ready;
        t_act  act;
        t_jmp  jmp;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic in_fire;
        logic is_op;
        logic is_div;
        logic under;
        logic div_last;
        logic last;
        logic out_busy;
    } t_flags;

    // microcode ROM
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        unique case (step)
            S_FETCH:  w = '{1'b1, ACT_NONE,  J_WAIT_IN,    S_FETCH};
            S_DECODE: w = '{1'b0, ACT_NONE,  J_IF_OP,      S_OPCHK};
            S_PUSH:   w = '{1'b0, ACT_PUSH,  J_GOTO,       S_END};
            S_OPCHK:  w = '{1'b0, ACT_OPCHK, J_IF_UNDER,   S_END};
            S_LOAD:   w = '{1'b0, ACT_LOAD,  J_IF_NOTDIV,  S_WB};
            S_DIV:    w = '{1'b0, ACT_DIV,   J_DIV_LOOP,   S_DIV};
            S_WB:     w = '{1'b0, ACT_WB,    J_NEXT,       S_END};
            S_END:    w = '{1'b0, ACT_NONE,  J_IF_NOTLAST, S_FETCH};
            S_EMIT:   w = '{1'b0, ACT_EMIT,  J_OUT_WAIT,   S_FETCH};
            default:  w = '{1'b0, ACT_NONE,  J_GOTO,       S_FETCH};
        endcase
        return w;
    endfunction

    // magnitude of an 8-bit two's complement value (128 fits unsigned)
    function automatic logic [7:0] mag8(input logic [7:0] v);
        return v[7] ? 8'(8'd0 - v) : v;
    endfunction

endpackage

// ===== src/pse_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_in_if: expression character channel
// Carries one character word and its last marker with valid/ready.
// ----------------------------------------------------------------------------
interface pse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ===== src/pse_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_out_if: result channel
// Carries one result word (value and status) with valid/ready.
// ----------------------------------------------------------------------------
interface pse_out_if;
    logic               valid;
    logic               ready;
    logic signed [7:0]  value;
    logic [1:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== src/postfix_stack_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: microcoded postfix expression evaluator
// Digits push, + - * / pop two and push the 8-bit wrapped result; the word
// marked last yields the top of stack and a status, then clears the stack.
//
//   channel    dir  fields             handshake
//   i_expr     in   symbol[7:0], last  valid/ready
//   o_result   out  value[7:0], status valid/ready
//
// Digits and ignored characters take the push step, underflowing operators
// skip to the end, + - * load and write back, and / runs the eight-step
// divider loop in between. A last word then loads the result register.
// Reset clears the step counter, stack count, sticky error and result valid.
// A pending result does not block new words; only the next result waits.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pse_in_if.sink     i_expr,
    pse_out_if.source  o_result
);

    pse_pkg::t_uword uword;
    pse_pkg::t_flags flags;

    // microprogram control
    pse_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uword)
    );

    // stack and arithmetic
    pse_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_uword  (uword),
        .o_flags  (flags),
        .i_expr   (i_expr),
        .o_result (o_result)
    );

endmodule

// ===== src/pse_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, then registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pse_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_sequencer: microprogram step counter
// Reads the control word for the current step and picks the next step
// from the jump field and the datapath flags.
// ----------------------------------------------------------------------------
module pse_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pse_pkg::t_flags i_flags,
    output pse_pkg::t_uword o_uword
);

    pse_pkg::t_step  r_step;
    pse_pkg::t_step  n_step;
    pse_pkg::t_uword uw;
    pse_pkg::t_step  step_inc;

    // fetch control word
    assign uw       = pse_pkg::ucode(r_step);
    assign o_uword  = uw;
    assign step_inc = r_step + pse_pkg::t_step'(1);

    // resolve jump
    always_comb begin
        unique case (uw.jmp)
            pse_pkg::J_NEXT:       n_step = step_inc;
            pse_pkg::J_GOTO:       n_step = uw.target;
            pse_pkg::J_WAIT_IN:    n_step = i_flags.in_fire ? step_inc : r_step;
            pse_pkg::J_IF_OP:      n_step = i_flags.is_op ? uw.target : step_inc;
            pse_pkg::J_IF_UNDER:   n_step = i_flags.under ? uw.target : step_inc;
            pse_pkg::J_IF_NOTDIV:  n_step = i_flags.is_div ? step_inc : uw.target;
            pse_pkg::J_DIV_LOOP:   n_step = i_flags.div_last ? step_inc : r_step;
            pse_pkg::J_IF_NOTLAST: n_step = i_flags.last ? step_inc : uw.target;
            pse_pkg::J_OUT_WAIT:   n_step = i_flags.out_busy ? r_step : uw.target;
            default:               n_step = pse_pkg::S_FETCH;
        endcase
    end

    // advance step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= pse_pkg::S_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== src/pse_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_datapath: operand stack, ALU, divider and result register
// Executes one action per cycle as the control word asks; keeps the top
// of stack in a register and the whole stack, top included, in RAM.
// ----------------------------------------------------------------------------
module pse_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pse_pkg::t_uword i_uword,
    output pse_pkg::t_flags o_flags,
    pse_in_if.sink          i_expr,
    pse_out_if.source       o_result
);

    localparam int CNT_W  = pse_pkg::CNT_W;
    localparam int ADDR_W = pse_pkg::ADDR_W;

    // captured character
    logic [7:0]                     r_sym;
    logic                           r_last;
    // stack state
    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               n_count;
    logic [7:0]                     r_top;
    logic [7:0]                     n_top;
    pse_pkg::t_status               r_err;
    pse_pkg::t_status               n_err;
    // operands and divider
    logic [7:0]                     r_opa;
    logic [7:0]                     r_opb;
    logic [7:0]                     r_quo;
    logic [7:0]                     r_rem;
    logic [7:0]                     r_dvs;
    logic [pse_pkg::DIVCNT_W-1:0]   r_div_cnt;
    // result register
    logic                           r_out_valid;
    logic [7:0]                     r_out_value;
    pse_pkg::t_status               r_out_status;

    logic                           in_fire;
    logic                           is_digit;
    logic                           is_op;
    logic                           is_div;
    logic                           full;
    logic                           under;
    logic                           out_busy;
    logic                           do_push;
    logic                           do_emit;
    logic [CNT_W-1:0]               cnt_m2;
    logic [7:0]                     digit_val;
    logic [15:0]                    prod;
    logic [8:0]                     rem_sh;
    logic                           rem_ge;
    logic [7:0]                     quo_signed;
    logic [7:0]                     alu_res;
    logic                           ram_we;
    logic [ADDR_W-1:0]              ram_waddr;
    logic [7:0]                     ram_wdata;
    logic [7:0]                     ram_rdata;
    pse_pkg::t_status               fin_err;

    // input handshake
    assign i_expr.ready = i_uword.in_ready;
    assign in_fire      = i_expr.valid && i_uword.in_ready;

    // classify character
    assign is_digit  = (r_sym >= pse_pkg::CH_ZERO) && (r_sym <= pse_pkg::CH_NINE);
    assign is_div    = (r_sym == pse_pkg::CH_SLASH);
    assign is_op     = (r_sym == pse_pkg::CH_PLUS) || (r_sym == pse_pkg::CH_MINUS)
                    || (r_sym == pse_pkg::CH_STAR) || is_div;
    assign digit_val = r_sym - pse_pkg::CH_ZERO;

    // stack bounds
    assign full   = (r_count >= CNT_W'(pse_pkg::STACK_DEPTH));
    assign under  = (r_count < CNT_W'(2));
    assign cnt_m2 = r_count - CNT_W'(2);

    assign out_busy = r_out_valid && !o_result.ready;
    assign do_push  = (i_uword.act == pse_pkg::ACT_PUSH) && is_digit;
    assign do_emit  = (i_uword.act == pse_pkg::ACT_EMIT) && !out_busy;

    assign o_flags = '{in_fire:  in_fire,
                       is_op:    is_op,
                       is_div:   is_div,
                       under:    under,
                       div_last: (r_div_cnt == pse_pkg::DIVCNT_W'(pse_pkg::DIV_STEPS - 1)),
                       last:     r_last,
                       out_busy: out_busy};

    // restoring divide step on magnitudes
    assign rem_sh = {r_rem, r_quo[7]};
    assign rem_ge = (rem_sh >= {1'b0, r_dvs});

    // ALU result
    assign prod       = r_opa * r_opb;
    assign quo_signed = (r_opa[7] ^ r_opb[7]) ? 8'(8'd0 - r_quo) : r_quo;
    always_comb begin
        priority if (r_sym == pse_pkg::CH_PLUS) begin
            alu_res = r_opa + r_opb;
        end else if (r_sym == pse_pkg::CH_MINUS) begin
            alu_res = r_opa - r_opb;
        end else if (r_sym == pse_pkg::CH_STAR) begin
            alu_res = prod[7:0];
        end else if (r_opb == 8'd0) begin
            alu_res = 8'd0;
        end else begin
            alu_res = quo_signed;
        end
    end

    // stack RAM access
    assign ram_we    = (do_push && !full) || (i_uword.act == pse_pkg::ACT_WB);
    assign ram_waddr = (i_uword.act == pse_pkg::ACT_WB) ? cnt_m2[ADDR_W-1:0]
                                                         : r_count[ADDR_W-1:0];
    assign ram_wdata = (i_uword.act == pse_pkg::ACT_WB) ? alu_res : digit_val;

    pse_ram #(
        .WIDTH (8),
        .DEPTH (pse_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_uword.act == pse_pkg::ACT_OPCHK),
        .i_raddr (cnt_m2[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // final status at the last character
    assign fin_err = (r_err != pse_pkg::ST_OK) ? r_err
                   : ((r_count == '0) ? pse_pkg::ST_UNDER : pse_pkg::ST_OK);

    // next stack state and sticky error
    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        n_err   = r_err;
        unique case (i_uword.act)
            pse_pkg::ACT_PUSH: begin
                if (do_push && full) begin
                    if (r_err == pse_pkg::ST_OK) n_err = pse_pkg::ST_OVER;
                end else if (do_push) begin
                    n_count = r_count + CNT_W'(1);
                    n_top   = digit_val;
                end
            end
            pse_pkg::ACT_OPCHK: begin
                if (under && r_err == pse_pkg::ST_OK) n_err = pse_pkg::ST_UNDER;
            end
            pse_pkg::ACT_WB: begin
                n_count = r_count - CNT_W'(1);
                n_top   = alu_res;
                if (is_div && r_opb == 8'd0 && r_err == pse_pkg::ST_OK) begin
                    n_err = pse_pkg::ST_DIVZERO;
                end
            end
            pse_pkg::ACT_EMIT: begin
                if (do_emit) begin
                    n_count = '0;
                    n_err   = pse_pkg::ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= pse_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (in_fire) begin
            r_sym  <= i_expr.symbol;
            r_last <= i_expr.last;
        end
        if (i_uword.act == pse_pkg::ACT_LOAD) begin
            r_opa     <= ram_rdata;
            r_opb     <= r_top;
            r_quo     <= pse_pkg::mag8(ram_rdata);
            r_dvs     <= pse_pkg::mag8(r_top);
            r_rem     <= 8'd0;
            r_div_cnt <= '0;
        end else if (i_uword.act == pse_pkg::ACT_DIV) begin
            r_rem     <= rem_ge ? 8'(rem_sh - {1'b0, r_dvs}) : rem_sh[7:0];
            r_quo     <= {r_quo[6:0], rem_ge};
            r_div_cnt <= r_div_cnt + pse_pkg::DIVCNT_W'(1);
        end
        if (do_emit) begin
            r_out_value  <= (fin_err == pse_pkg::ST_OK) ? r_top : 8'd0;
            r_out_status <= fin_err;
        end
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.value  = r_out_value;
    assign o_result.status = r_out_status;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(pse_pkg::STACK_DEPTH))
        else $error("stack count above depth");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_emit |=> (r_count == '0) && (r_err == pse_pkg::ST_OK) && r_out_valid)
        else $error("emit did not clear the stack");

    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != pse_pkg::ST_OK) |-> (r_out_value == 8'd0))
        else $error("error result carries a nonzero value");

    a_wb_pops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uword.act == pse_pkg::ACT_WB) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("operator writeback did not net one pop");
`endif

endmodule
